// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// cons must hold at the next edge after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// Wake-up slot scheduler package
// Shared widths, constants, register indexes and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int PROD_W = 42;  // elapsed times ppm
    localparam int DIV_W = 32;   // beat dividend width
    localparam int DVS_W = 16;   // beat divisor width
    localparam int CNT_W = 6;    // step count width
    localparam int BEAT_STEPS = 32;

    localparam logic [19:0]      DRIFT_DIVISOR = 20'd1000000;
    // 1000000 = 64 * 15625; exact reciprocal of 15625 for dividends below 2^32
    localparam logic [13:0]      DRIFT_ODD     = 14'd15625;
    localparam logic [32:0]      DRIFT_RECIP   = 33'd4503599628;
    localparam logic [4:0]       LENGTH_MARGIN = 5'd16;
    localparam logic [15:0]      LENGTH_MAX    = 16'hFFFF;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_MISSED = 2'd2;

    localparam logic [2:0] REG_CAD_BEAT    = 3'd0;
    localparam logic [2:0] REG_PPM         = 3'd1;
    localparam logic [2:0] REG_FRAGMENT    = 3'd2;
    localparam logic [2:0] REG_MIN_PREAMB  = 3'd3;
    localparam logic [2:0] REG_MAX_WAKEUP  = 3'd4;
    localparam logic [2:0] REG_MISSED_LIM  = 3'd5;

    localparam logic [15:0] RST_CAD_BEAT   = 16'd1000;
    localparam logic [9:0]  RST_PPM        = 10'd40;
    localparam logic [11:0] RST_FRAGMENT   = 12'd20;
    localparam logic [11:0] RST_MIN_PREAMB = 12'd20;
    localparam logic [15:0] RST_MAX_WAKEUP = 16'd1500;
    localparam logic [7:0]  RST_MISSED_LIM = 8'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: rtl/wss_if.sv
// ----------------------------------------------------------------------------
// Wake-up slot scheduler channels
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wss_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [15:0] ack_delay_ms;
    modport source (output valid, op, now_ms, ack_delay_ms, input ready);
    modport sink   (input valid, op, now_ms, ack_delay_ms, output ready);
endinterface

interface wss_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_send_slot_ms;
    logic        send_chan;
    logic [15:0] wakeup_length_ms;
    modport source (output valid, next_send_slot_ms, send_chan, wakeup_length_ms,
                    input ready);
    modport sink   (input valid, next_send_slot_ms, send_chan, wakeup_length_ms,
                    output ready);
endinterface

interface wss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/wss_div.sv
// ----------------------------------------------------------------------------
// Wake-up slot scheduler divider
// Restoring divider, one quotient bit per cycle, for the beat count.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_div import wss_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// File: rtl/wakeup_slot_scheduler_top.sv
// ----------------------------------------------------------------------------
// Wake-up slot scheduler
// Plans the start time, channel and length of a wake-up sequence.
// ----------------------------------------------------------------------------
// The event channel is ready only while the sequencer is idle. Ack-received,
// ack-missed and unused words are handled in the idle state itself. A start
// word with the missed-ack count below its limit works out the drift term
// (product, then a reciprocal multiplication in two base-2^18 digits, then
// the saturated length); with the count at its limit the maximum length is
// taken and the window is worked out at once. A positive distance with a
// nonzero beat then goes through the bit-serial beat divider. A finished
// result waits in an output register and does not hold up the next event
// word; a start word finishing while that register is still full waits
// until it drains. Register writes are always accepted and should only be
// made while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module wakeup_slot_scheduler_top import wss_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wss_evt_if.sink    i_evt,
    wss_res_if.source  o_res,
    wss_cfg_if.sink    i_cfg
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DRH  = 4'd2;
    localparam logic [3:0] S_DRR  = 4'd3;
    localparam logic [3:0] S_DRL  = 4'd4;
    localparam logic [3:0] S_LEN  = 4'd5;
    localparam logic [3:0] S_WIN  = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_BTW  = 4'd8;
    localparam logic [3:0] S_STP  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    // registers
    logic [15:0] r_cad;
    logic [9:0]  r_ppm;
    logic [11:0] r_frag;
    logic [11:0] r_pre;
    logic [15:0] r_max;
    logic [7:0]  r_lim;

    // state
    logic [31:0] r_listen;
    logic [31:0] r_last_ack;
    logic [7:0]  r_missed;
    logic        r_chan;
    logic [31:0] r_last_slot;
    logic [15:0] r_last_len;

    // working
    logic [3:0]        r_state;
    logic [31:0]       r_now;
    logic [PROD_W-1:0] r_prod;
    logic [4:0]        r_qh;
    logic [31:0]       r_z;
    logic [22:0]       r_drift;
    logic [15:0]       r_len;
    logic [31:0]       r_win;
    logic [31:0]       r_d;
    logic [30:0]       r_n;
    logic [31:0]       r_nc;

    logic        r_out_vld;
    logic [31:0] r_out_slot;
    logic        r_out_chan;
    logic [15:0] r_out_len;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic              w_evt_acc;
    logic              w_cfg_acc;
    logic              w_out_free;
    logic [31:0]       w_elapsed;
    logic [PROD_W-1:0] w_mprod;
    logic [31:0]       w_rq_in;
    logic [64:0]       w_rq_prod;
    logic [18:0]       w_rq;
    logic [17:0]       w_rh;
    logic [12:0]       w_base;
    logic [24:0]       w_lsum;
    logic [15:0]       w_lsat;
    logic [17:0]       w_ldiff;
    logic [17:0]       w_ladj;
    logic [17:0]       w_half;
    logic [31:0]       w_win;
    logic              w_beats;
    logic [31:0]       w_dplus;
    logic [46:0]       w_ncad;
    logic [31:0]       w_slot;

    wss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_evt.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_evt_acc   = i_evt.valid && i_evt.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_out_vld || o_res.ready;

    assign w_elapsed = r_now - r_last_ack;
    assign w_mprod   = PROD_W'(w_elapsed) * PROD_W'(r_ppm);
    assign w_base    = {1'b0, r_frag} + {1'b0, r_pre};

    // product / 64 split into two base-2^18 digits, long-divided by 15625 high digit first
    assign w_rq_in   = (r_state == S_DRH) ? {14'd0, r_prod[41:24]} : r_z;
    assign w_rq_prod = 65'(w_rq_in) * 65'(DRIFT_RECIP);
    assign w_rq      = w_rq_prod[64:46];
    assign w_rh      = r_prod[41:24] - 18'(r_qh) * 18'(DRIFT_ODD);

    assign w_lsum = 25'(r_drift) + 25'(w_base) + 25'(LENGTH_MARGIN);
    assign w_lsat = (w_lsum > 25'(LENGTH_MAX)) ? LENGTH_MAX : w_lsum[15:0];

    // signed half-difference, truncated toward zero
    assign w_ldiff = {2'b00, r_len} - {5'b00000, w_base};
    assign w_ladj  = w_ldiff + {17'd0, w_ldiff[17]};
    assign w_half  = 18'($signed(w_ladj) >>> 1);
    assign w_win   = {{14{w_half[17]}}, w_half};

    assign w_beats = (r_d != 32'd0) && !r_d[31] && (r_cad != 16'd0);
    assign w_dplus = r_d + {16'd0, r_cad} - 32'd1;
    assign w_ncad  = r_n * r_cad;
    assign w_slot  = r_listen + r_nc - r_win + {15'd0, r_cad, 1'b0};

    always_comb begin
        w_req = '0;
        if (r_state == S_CHK && w_beats) begin
            w_req.start    = 1'b1;
            w_req.dividend = w_dplus;
            w_req.divisor  = DVS_W'(r_cad);
            w_req.steps    = CNT_W'(BEAT_STEPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cad <= RST_CAD_BEAT;
            r_ppm <= RST_PPM;
            r_frag <= RST_FRAGMENT;
            r_pre <= RST_MIN_PREAMB;
            r_max <= RST_MAX_WAKEUP;
            r_lim <= RST_MISSED_LIM;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.index)
                REG_CAD_BEAT:   r_cad  <= i_cfg.data;
                REG_PPM:        r_ppm  <= i_cfg.data[9:0];
                REG_FRAGMENT:   r_frag <= i_cfg.data[11:0];
                REG_MIN_PREAMB: r_pre  <= i_cfg.data[11:0];
                REG_MAX_WAKEUP: r_max  <= i_cfg.data;
                REG_MISSED_LIM: r_lim  <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_listen    <= '0;
            r_last_ack  <= '0;
            r_missed    <= RST_MISSED_LIM;
            r_chan      <= 1'b0;
            r_last_slot <= '0;
            r_last_len  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_evt_acc) begin
                        r_now <= i_evt.now_ms;
                        case (i_evt.op)
                            OP_START: begin
                                if (r_missed >= r_lim) begin
                                    r_len   <= r_max;
                                    r_state <= S_WIN;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            OP_ACK: begin
                                r_last_ack <= i_evt.now_ms;
                                r_missed   <= '0;
                                r_listen   <= r_last_slot + {16'd0, r_last_len}
                                              - {16'd0, i_evt.ack_delay_ms};
                            end
                            OP_MISSED: begin
                                if (r_missed != 8'hFF) begin
                                    r_missed <= r_missed + 8'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= w_mprod;
                    r_state <= S_DRH;
                end
                S_DRH: begin
                    r_qh    <= w_rq[4:0];
                    r_state <= S_DRR;
                end
                S_DRR: begin
                    r_z     <= {w_rh[13:0], r_prod[23:6]};
                    r_state <= S_DRL;
                end
                S_DRL: begin
                    r_drift <= {r_qh, w_rq[17:0]};
                    r_state <= S_LEN;
                end
                S_LEN: begin
                    r_len   <= w_lsat;
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    r_win   <= w_win;
                    r_d     <= r_now + w_win - r_listen;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_beats) begin
                        r_state <= S_BTW;
                    end else begin
                        r_n     <= '0;
                        r_state <= S_STP;
                    end
                end
                S_BTW: begin
                    if (w_rsp.done) begin
                        r_n     <= w_rsp.quotient[30:0];
                        r_state <= S_STP;
                    end
                end
                S_STP: begin
                    r_nc    <= w_ncad[31:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_slot  <= w_slot;
                        r_out_chan  <= r_chan ^ r_n[0];
                        r_out_len   <= r_len;
                        r_chan      <= r_chan ^ r_n[0];
                        r_last_slot <= w_slot;
                        r_last_len  <= r_len;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.next_send_slot_ms = r_out_slot;
    assign o_res.send_chan         = r_out_chan;
    assign o_res.wakeup_length_ms  = r_out_len;

    `ASSERT_ALWAYS(a_div_start_idle, !w_req.start || !w_rsp.busy, "divider restarted")
    `ASSERT_ALWAYS(a_div_busy_waits, !w_rsp.busy || r_state == S_BTW, "divider busy early")
    `ASSERT_NEXT(a_ack_clears, w_evt_acc && i_evt.op == OP_ACK, r_missed == 8'd0, "misses kept")
    `ASSERT_NEXT(a_fin_loads, r_state == S_FIN && w_out_free, r_out_vld && r_state == S_IDLE, "no load")

endmodule

`default_nettype wire

// File: bench/wss_slot_checker.sv
// ----------------------------------------------------------------------------
// Wake-up slot scheduler checker
// Watches the event, result and register channels, keeps its own copy of the
// scheduling state and settings, works out the slot plan of every start word
// and compares each result word, field by field, with the oldest plan queued.
// ----------------------------------------------------------------------------
module wss_slot_checker import wss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    wss_evt_if   i_evt,
    wss_res_if   i_res,
    wss_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] slot;
        logic        chan;
        logic [15:0] len;
    } t_slot_plan;

    logic [15:0] beat_ms;
    logic [9:0]  ppm;
    logic [11:0] frag_ms;
    logic [11:0] pre_ms;
    logic [15:0] max_len;
    logic [7:0]  miss_lim;

    logic [31:0] listen_at;
    logic [31:0] last_ack;
    logic [7:0]  miss_cnt;
    logic        chan;
    logic [31:0] last_slot;
    logic [15:0] last_len;

    t_slot_plan slot_plans[$];
    int         fails  = 0;
    int         queued = 0;

    assign o_fail_count = fails;
    assign o_pending    = queued;

    task automatic set_register(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            REG_CAD_BEAT:   beat_ms  = val;
            REG_PPM:        ppm      = val[9:0];
            REG_FRAGMENT:   frag_ms  = val[11:0];
            REG_MIN_PREAMB: pre_ms   = val[11:0];
            REG_MAX_WAKEUP: max_len  = val;
            REG_MISSED_LIM: miss_lim = val[7:0];
            default: ;
        endcase
    endtask

    task automatic schedule_word(input logic [1:0] op, input logic [31:0] now,
                                 input logic [15:0] dly);
        logic [31:0] base, elapsed, win, gap_ms, stepped, slot;
        logic [63:0] drift, len_full, steps;
        logic [15:0] len;
        int          len_i, base_i, half;
        t_slot_plan  plan;
        case (op)
            OP_START: begin
                base = 32'(frag_ms) + 32'(pre_ms);
                if (miss_cnt >= miss_lim) begin
                    len = max_len;
                end else begin
                    elapsed  = now - last_ack;
                    drift    = (64'(elapsed) * 64'(ppm)) / 64'(DRIFT_DIVISOR);
                    len_full = 64'(base) + drift + 64'(LENGTH_MARGIN);
                    len      = (len_full > 64'(LENGTH_MAX)) ? LENGTH_MAX : len_full[15:0];
                end
                len_i  = len;
                base_i = base;
                half   = (len_i - base_i) / 2;
                win    = half;
                gap_ms = now + win - listen_at;
                steps  = '0;
                if (gap_ms != '0 && !gap_ms[31] && beat_ms != '0) begin
                    steps = (64'(gap_ms) + 64'(beat_ms) - 64'd1) / 64'(beat_ms);
                end
                stepped   = listen_at + 32'(steps * 64'(beat_ms));
                slot      = stepped - win + {15'd0, beat_ms, 1'b0};
                chan      = chan ^ steps[0];
                last_slot = slot;
                last_len  = len;
                plan.slot = slot;
                plan.chan = chan;
                plan.len  = len;
                slot_plans.push_back(plan);
            end
            OP_ACK: begin
                last_ack  = now;
                listen_at = last_slot + 32'(last_len) - 32'(dly);
                miss_cnt  = '0;
            end
            OP_MISSED: begin
                if (miss_cnt != '1) miss_cnt++;
            end
            default: ;
        endcase
    endtask

    task automatic compare_slot(input t_slot_plan got);
        t_slot_plan want;
        if (slot_plans.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("unexpected result word: slot %h chan %0d len %0d",
                         got.slot, got.chan, got.len);
            end
        end else begin
            want = slot_plans.pop_front();
            if (got.slot !== want.slot || got.chan !== want.chan || got.len !== want.len) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch at %0t: slot %h/%h chan %0d/%0d len %0d/%0d (exp/got)",
                             $time, want.slot, got.slot, want.chan, got.chan,
                             want.len, got.len);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_plan got;
        if (!i_rst_n) begin
            beat_ms   = RST_CAD_BEAT;
            ppm       = RST_PPM;
            frag_ms   = RST_FRAGMENT;
            pre_ms    = RST_MIN_PREAMB;
            max_len   = RST_MAX_WAKEUP;
            miss_lim  = RST_MISSED_LIM;
            listen_at = '0;
            last_ack  = '0;
            miss_cnt  = RST_MISSED_LIM;
            chan      = 1'b0;
            last_slot = '0;
            last_len  = '0;
            slot_plans.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.slot = i_res.next_send_slot_ms;
                got.chan = i_res.send_chan;
                got.len  = i_res.wakeup_length_ms;
                compare_slot(got);
            end
            if (i_cfg.valid && i_cfg.ready) set_register(i_cfg.index, i_cfg.data);
            if (i_evt.valid && i_evt.ready) begin
                schedule_word(i_evt.op, i_evt.now_ms, i_evt.ack_delay_ms);
            end
        end
        queued = slot_plans.size();
    end

endmodule

// File: bench/wakeup_slot_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// Wake-up slot scheduler testbench
// Drives directed and random event words through the scheduler under a range
// of register settings, with random idling on both channels, long result
// hold-offs and drains between settings; the checker judges every result word.
// ----------------------------------------------------------------------------
module wakeup_slot_scheduler_top_test import wss_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_words;

    bit          gaps_on = 1'b1;
    int          stall_reqs = 0;
    logic [15:0] setting [6];

    wss_evt_if evt_ch ();
    wss_res_if res_ch ();
    wss_cfg_if cfg_ch ();

    wakeup_slot_scheduler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    wss_slot_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (evt_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random idling, plus long hold-offs on request
    initial begin
        int stall_seen;
        int hold_left;
        stall_seen   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_reqs != stall_seen) begin
                stall_seen = stall_reqs;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(gaps_on && $urandom_range(99) < 12);
            end
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [31:0] now,
                              input logic [15:0] dly);
        while (gaps_on && $urandom_range(99) < 12) begin
            evt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.op           <= op;
        evt_ch.now_ms       <= now;
        evt_ch.ack_delay_ms <= dly;
        do @(posedge i_clk); while (!evt_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        evt_ch.valid <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned beat, input int unsigned ppm,
                             input int unsigned frag, input int unsigned pre,
                             input int unsigned maxw, input int unsigned lim);
        settle();
        setting[REG_CAD_BEAT]   = 16'(beat);
        setting[REG_PPM]        = 16'(ppm);
        setting[REG_FRAGMENT]   = 16'(frag);
        setting[REG_MIN_PREAMB] = 16'(pre);
        setting[REG_MAX_WAKEUP] = 16'(maxw);
        setting[REG_MISSED_LIM] = 16'(lim);
        for (int i = REG_CAD_BEAT; i <= REG_MISSED_LIM; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= 3'(i);
            cfg_ch.data  <= setting[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return lo;
        if (r < 40) return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int unsigned pick_beat();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 45) return $urandom_range(3000, 1);
        return pick(1, 65535);
    endfunction

    task automatic random_settings(input int unsigned lim);
        configure(pick_beat(), pick(0, 1000), pick(0, 4095), pick(0, 4095),
                  pick(0, 65535), lim);
    endtask

    initial begin
        logic [31:0] rtc;
        logic [1:0]  op;
        int unsigned r;
        int          words;

        i_rst_n             = 1'b0;
        evt_ch.valid        = 1'b0;
        evt_ch.op           = OP_START;
        evt_ch.now_ms       = '0;
        evt_ch.ack_delay_ms = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_CAD_BEAT;
        cfg_ch.data         = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: miss count starts at its limit
        send_event(OP_START, 32'h0000_0000, 16'h0000);
        send_event(OP_START, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);

        // raised limit leaves the miss count alone
        configure(1000, 40, 20, 20, 1500, 3);
        send_event(OP_START, 32'h0000_1000, 16'h0000);
        send_event(OP_MISSED, 32'h0000_0000, 16'h0000);
        send_event(OP_START, 32'h0000_2000, 16'h0000);
        send_event(OP_ACK, 32'hFFFF_FFF0, 16'hFFFF);
        send_event(OP_START, 32'h0000_0010, 16'h0000);
        send_event(OP_START, 32'h8000_0000, 16'h0000);
        send_event(OP_ACK, 32'h0000_0000, 16'h0000);
        send_event(OP_START, 32'h7FFF_FFFF, 16'h0000);

        // zero beat
        configure(0, 1000, 4095, 4095, 65535, 255);
        send_event(OP_START, 32'h1234_5678, 16'h0000);
        send_event(OP_ACK, 32'h1234_6000, 16'd100);
        send_event(OP_START, 32'h1234_7000, 16'h0000);

        // max length below base: negative window
        configure(65535, 0, 4095, 4095, 0, 0);
        send_event(OP_START, 32'h0000_0000, 16'h0000);
        send_event(OP_MISSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(OP_START, 32'hFFFF_0000, 16'h0000);

        configure(1, 1000, 0, 0, 65535, 255);
        send_event(OP_ACK, 32'h0000_0010, 16'h0000);
        send_event(OP_START, 32'h5000_0000, 16'h0000);
        send_event(OP_START, 32'h5000_0001, 16'h0000);

        // miss count saturates rather than wrapping
        random_settings(255);
        rtc = $urandom;
        send_event(OP_ACK, rtc, 16'($urandom_range(3000)));
        for (int i = 0; i < 260; i++) send_event(OP_MISSED, $urandom, 16'($urandom));
        send_event(OP_START, rtc + 32'd500, 16'($urandom));
        send_event(OP_START, rtc + 32'd2500, 16'($urandom));

        for (int ph = 0; ph < 10; ph++) begin
            random_settings(pick(0, 255));
            gaps_on = (ph != 4);
            if (ph == 2 || ph == 6) stall_reqs++;
            rtc   = $urandom;
            words = 0;
            while (words < 100) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    op = 2'($urandom_range(3));
                    send_event(op, $urandom, 16'($urandom));
                    if (op != OP_UNUSED) words++;
                end else begin
                    r = $urandom_range(99);
                    if (r < 70) rtc += $urandom_range(3000);
                    else if (r < 90) rtc += $urandom_range(200000);
                    else rtc = $urandom;
                    send_event(OP_START, rtc, 16'($urandom));
                    words++;
                    r = $urandom_range(99);
                    if (r < 65) begin
                        rtc += $urandom_range(3000);
                        send_event(OP_ACK, rtc, ($urandom_range(99) < 85)
                                   ? 16'($urandom_range(3000)) : 16'($urandom));
                        words++;
                    end else if (r < 85) begin
                        send_event(OP_MISSED, rtc, 16'($urandom));
                        words++;
                    end
                end
            end
        end
        gaps_on = 1'b1;

        settle();
        if (fail_count == 0 && pending_words == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wss_pkg.sv
rtl/wss_if.sv
rtl/wss_div.sv
rtl/wakeup_slot_scheduler_top.sv
bench/wss_slot_checker.sv
bench/wakeup_slot_scheduler_top_test.sv
